[design/assert_macros.svh]
// Assertion macros used by the checker file of the step pulse generator.
// Needs nothing else; every macro takes its own clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Check that a condition in one cycle implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

`endif

[design/fcspg_pkg.sv]
// Shared types and constants of the four-channel step pulse generator.
// Used by the top level and by its port checker; depends on nothing.
`default_nettype none

package fcspg_pkg;

	localparam int CHANNELS       = 4;
	localparam int CMD_W          = 2;
	localparam int SPEED_W        = 16;
	localparam int POS_W          = 16;
	localparam int CNT_W          = 16;
	localparam int PERIOD_W       = 17;
	localparam int IN_DATA_W      = 72;
	localparam int OUT_DATA_W     = 80;

	localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 17'd600;

	// Request kinds carried on the input tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_SPEED  = 2'd1,
		CMD_ENABLE = 2'd2
	} cmd_t;

	typedef logic [POS_W-1:0] pos_t;

endpackage

`default_nettype wire

[design/four_channel_step_pulse_generator_unit.sv]
// Top level of the four-channel step/direction pulse generator.
// Depends on fcspg_pkg for widths, reset values and request kinds.
`default_nettype none

// Four stepper channels, one request per cycle unless stalled. A tick request
// advances every channel counter: a channel steps (pulse high, position +/-1)
// when its counter is zero, drops the pulse at half its period and wraps at
// the period; a period of zero halts the channel with the pulse low. A speed
// request loads four signed speeds (sign = direction, magnitude = period in
// ticks), an enable request loads the four driver enables, and an unused kind
// changes nothing. Every request returns one result showing the state after it.
// A request is taken every cycle unless stalled; it passes the input register,
// then the combinational channel update, into the result register, from which
// its result is offered. A stalled result holds the input register, so up to
// two requests wait inside before the input stalls.
// Reset: period 600, forward, enabled, counters, pulses and positions zero.
module four_channel_step_pulse_generator_unit
	import fcspg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// speed_a[15:0], speed_b[31:16], speed_c[47:32], speed_d[63:48],
	// enable_mask[67:64], zero fill[71:68]
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// cmd[1:0]
	input  wire logic [CMD_W-1:0]      s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// pulse_bits[3:0], dir_bits[7:4], enable_bits[11:8], position_a[27:12],
	// position_b[43:28], position_c[59:44], position_d[75:60], zero fill[79:76]
	output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

	// Input register
	logic                     valid_s1;
	logic [CMD_W-1:0]         cmd_s1;
	logic [SPEED_W-1:0]       speed_s1 [CHANNELS];
	logic [CHANNELS-1:0]      mask_s1;

	// Result register
	logic                     valid_s2;
	logic [OUT_DATA_W-1:0]    res_s2;

	// Channel state
	logic [CNT_W-1:0]         cnt_q    [CHANNELS];
	logic [PERIOD_W-1:0]      period_q [CHANNELS];
	pos_t                     pos_q    [CHANNELS];
	logic [CHANNELS-1:0]      fwd_q;
	logic [CHANNELS-1:0]      pulse_q;
	logic [CHANNELS-1:0]      en_q;

	// Next channel state
	logic [CNT_W-1:0]         cnt_d    [CHANNELS];
	logic [PERIOD_W-1:0]      period_d [CHANNELS];
	pos_t                     pos_d    [CHANNELS];
	logic [CHANNELS-1:0]      fwd_d;
	logic [CHANNELS-1:0]      pulse_d;
	logic [CHANNELS-1:0]      en_d;

	logic                     in_acc;
	logic                     adv;

	// Advance the held request when the result register is free or drained
	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Hold the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1      <= s_axis_tuser;
			speed_s1[0] <= s_axis_tdata[15:0];
			speed_s1[1] <= s_axis_tdata[31:16];
			speed_s1[2] <= s_axis_tdata[47:32];
			speed_s1[3] <= s_axis_tdata[63:48];
			mask_s1     <= s_axis_tdata[67:64];
		end
	end

	// Magnitude of a signed speed as a period, 0..32768
	function automatic logic [PERIOD_W-1:0] v_neg_mag(input logic [SPEED_W-1:0] v);
		logic [PERIOD_W-1:0] ext;
		ext = {1'b0, v};
		return v[SPEED_W-1] ? (PERIOD_W'(17'h10000) - ext) : ext;
	endfunction

	// Work out the state after the held request, channel by channel
	always_comb begin
		logic [PERIOD_W-1:0] inc;
		logic [PERIOD_W-1:0] mag;
		for (int i = 0; i < CHANNELS; i++) begin
			cnt_d[i]    = cnt_q[i];
			period_d[i] = period_q[i];
			pos_d[i]    = pos_q[i];
			fwd_d[i]    = fwd_q[i];
			pulse_d[i]  = pulse_q[i];
			en_d[i]     = en_q[i];
			inc         = {1'b0, cnt_q[i]} + PERIOD_W'(1);
			mag         = v_neg_mag(speed_s1[i]);
			unique case (cmd_s1)
				CMD_TICK: begin
					if (period_q[i] == '0) begin
						// halted channel: pulse low, counter parked
						pulse_d[i] = 1'b0;
						cnt_d[i]   = '0;
					end else begin
						if (cnt_q[i] == '0) begin
							pulse_d[i] = 1'b1;
							pos_d[i]   = fwd_q[i] ? pos_q[i] + POS_W'(1)
							                      : pos_q[i] - POS_W'(1);
						end else if (cnt_q[i] == period_q[i][PERIOD_W-1:1]) begin
							pulse_d[i] = 1'b0;
						end
						cnt_d[i] = (inc >= period_q[i]) ? '0 : inc[CNT_W-1:0];
					end
				end
				CMD_SPEED: begin
					fwd_d[i]    = !speed_s1[i][SPEED_W-1];
					period_d[i] = mag;
				end
				CMD_ENABLE: begin
					en_d[i] = mask_s1[i];
				end
				default: begin
					// unused kind: report state unchanged
				end
			endcase
		end
	end

	// Commit channel state when the request moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				cnt_q[i]    <= '0;
				period_q[i] <= DEFAULT_PERIOD;
				pos_q[i]    <= '0;
			end
			fwd_q   <= '1;
			pulse_q <= '0;
			en_q    <= '1;
		end else if (adv) begin
			for (int i = 0; i < CHANNELS; i++) begin
				cnt_q[i]    <= cnt_d[i];
				period_q[i] <= period_d[i];
				pos_q[i]    <= pos_d[i];
			end
			fwd_q   <= fwd_d;
			pulse_q <= pulse_d;
			en_q    <= en_d;
		end
	end

	// Result register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= {4'b0000, pos_d[3], pos_d[2], pos_d[1], pos_d[0],
			           en_d, fwd_d, pulse_d};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2;

endmodule

`default_nettype wire

[design/fcspg_checker.sv]
// Port checker of the step pulse generator, bound to the top level.
// Depends on fcspg_pkg and on the assertion macros in assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module fcspg_checker
	import fcspg_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic                in_acc;
	logic                out_acc;
	logic                have_prev_q;
	pos_t                prev_pos_q [CHANNELS];
	pos_t                cur_pos    [CHANNELS];
	pos_t                delta      [CHANNELS];
	logic [CHANNELS-1:0] step_ok;
	logic [CHANNELS-1:0] moved_up;
	logic [CHANNELS-1:0] moved_down;
	logic [CHANNELS-1:0] cur_pulse;
	logic [CHANNELS-1:0] cur_dir;
	logic                seen_in_q;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign out_acc   = m_axis_tvalid && m_axis_tready;
	assign cur_pulse = m_axis_tdata[3:0];
	assign cur_dir   = m_axis_tdata[7:4];

	// Split the result into positions and compare with the last result
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			cur_pos[i]    = m_axis_tdata[12 + POS_W*i +: POS_W];
			delta[i]      = cur_pos[i] - prev_pos_q[i];
			moved_up[i]   = (delta[i] == POS_W'(1));
			moved_down[i] = (delta[i] == '1);
			step_ok[i]    = (delta[i] == '0) || moved_up[i] || moved_down[i];
		end
	end

	// Track the last delivered result and whether any request came in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			seen_in_q   <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				prev_pos_q[i] <= '0;
			end
		end else begin
			if (in_acc) begin
				seen_in_q <= 1'b1;
			end
			if (out_acc) begin
				have_prev_q <= 1'b1;
				for (int i = 0; i < CHANNELS; i++) begin
					prev_pos_q[i] <= cur_pos[i];
				end
			end
		end
	end

	// A stalled result stays put
	`ASSERT_ALWAYS(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// No result without an earlier request
	`ASSERT_IMPLIES(a_no_invented, clk, arst_n, m_axis_tvalid, seen_in_q, "result without any request")

	// Positions move by at most one step between results
	`ASSERT_IMPLIES(a_single_step, clk, arst_n, out_acc && have_prev_q, &step_ok, "position jumped by more than one step")

	// A step shows its pulse high and follows the direction bit
	`ASSERT_IMPLIES(a_step_pulse, clk, arst_n, out_acc && have_prev_q, ((moved_up | moved_down) & ~cur_pulse) == '0, "step without pulse")
	`ASSERT_IMPLIES(a_step_dir, clk, arst_n, out_acc && have_prev_q, ((moved_up & ~cur_dir) | (moved_down & cur_dir)) == '0, "step against direction bit")

endmodule

bind four_channel_step_pulse_generator_unit fcspg_checker u_fcspg_checker (.*);

`default_nettype wire
